/* hdl/csc_pkg.sv */
// ----------------------------------------------------------------------------
// csc_pkg
// Shared constants, types and helpers for the strength of connection block.
// ----------------------------------------------------------------------------
package csc_pkg;

	localparam int DEF_MAX_ROW_LEN = 32;
	localparam int DEF_INDEX_BITS  = 20;

	localparam int VALUE_W = 32;
	localparam int THETA_W = 17;
	localparam int POS_W   = 24;

	// two row banks: one filling, one draining
	localparam int ROW_BANKS = 2;
	localparam int BANK_W    = $clog2(ROW_BANKS);

	localparam logic signed [VALUE_W-1:0] Q_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic signed [VALUE_W-1:0] Q_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [POS_W-1:0]          POS_MAX = {POS_W{1'b1}};

	localparam logic [THETA_W-1:0] THETA_RESET = 17'd16384;

	// APB map: one register per 32-bit word
	localparam int                      APB_ADDR_W = 3;
	localparam logic [APB_ADDR_W-3:0]   REG_THETA  = '0;

	typedef struct packed {
		logic valid;
		logic full;
	} csc_q_status_t;

	// negate with saturation: the most negative value maps to the most positive
	function automatic logic signed [VALUE_W-1:0] neg_sat(input logic signed [VALUE_W-1:0] v);
		logic signed [VALUE_W-1:0] r;
		if (v == Q_MIN) begin
			r = Q_MAX;
		end else begin
			r = -v;
		end
		return r;
	endfunction

endpackage

/* hdl/csc_entry_if.sv */
// ----------------------------------------------------------------------------
// csc_entry_if
// Input channel: one nonzero of a sparse row per word.
// ----------------------------------------------------------------------------
interface csc_entry_if import csc_pkg::*; #(
	parameter int INDEX_BITS = DEF_INDEX_BITS
);
	logic                      valid;
	logic                      ready;
	logic [INDEX_BITS-1:0]     row_index;
	logic [INDEX_BITS-1:0]     column;
	logic signed [VALUE_W-1:0] value;
	logic                      last_in_row;

	modport source (output valid, output row_index, output column, output value,
		output last_in_row, input ready);
	modport sink (input valid, input row_index, input column, input value,
		input last_in_row, output ready);
endinterface

/* hdl/csc_result_if.sv */
// ----------------------------------------------------------------------------
// csc_result_if
// Output channel: one classified entry per word.
// ----------------------------------------------------------------------------
interface csc_result_if import csc_pkg::*; #(
	parameter int INDEX_BITS = DEF_INDEX_BITS
);
	logic                      valid;
	logic                      ready;
	logic [INDEX_BITS-1:0]     out_column;
	logic signed [VALUE_W-1:0] out_value;
	logic                      strong_res;
	logic [POS_W-1:0]          compact_position;
	logic                      row_done;

	modport source (output valid, output out_column, output out_value, output strong_res,
		output compact_position, output row_done, input ready);
	modport sink (input valid, input out_column, input out_value, input strong_res,
		input compact_position, input row_done, output ready);
endinterface

/* hdl/csc_queue.sv */
// ----------------------------------------------------------------------------
// csc_queue
// Row descriptor queue between front and back, one slot per row bank.
// ----------------------------------------------------------------------------
module csc_queue import csc_pkg::*; #(
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output csc_q_status_t    stat
);
	localparam int CW = $clog2(ROW_BANKS + 1);

	logic [WIDTH-1:0]  slots_q [ROW_BANKS];
	logic [BANK_W-1:0] wr_ptr_q;
	logic [BANK_W-1:0] rd_ptr_q;
	logic [CW-1:0]     count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + BANK_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + BANK_W'(1);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	assign pop_data   = slots_q[rd_ptr_q];
	assign stat.valid = (count_q != '0);
	assign stat.full  = (count_q == CW'(ROW_BANKS));

endmodule

/* hdl/csc_front.sv */
// ----------------------------------------------------------------------------
// csc_front
// Accepts nonzeros, writes them into the current row bank and tracks the
// largest negated off-diagonal value; hands a row descriptor on at row end.
// ----------------------------------------------------------------------------
module csc_front import csc_pkg::*; #(
	parameter  int MAX_ROW_LEN = DEF_MAX_ROW_LEN,
	parameter  int INDEX_BITS  = DEF_INDEX_BITS,
	localparam int ADDR_W      = $clog2(MAX_ROW_LEN),
	localparam int CNT_W       = $clog2(MAX_ROW_LEN + 1),
	localparam int DESC_W      = INDEX_BITS + VALUE_W + CNT_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	csc_entry_if.sink                  entries,
	input  csc_q_status_t              q_stat,
	output logic                       wr_en,
	output logic [BANK_W+ADDR_W-1:0]   wr_addr,
	output logic [INDEX_BITS-1:0]      wr_column,
	output logic signed [VALUE_W-1:0]  wr_value,
	output logic                       push,
	output logic [DESC_W-1:0]          desc
);
	typedef struct packed {
		logic [INDEX_BITS-1:0]     row;
		logic signed [VALUE_W-1:0] max;
		logic [CNT_W-1:0]          count;
	} desc_t;

	logic [CNT_W-1:0]          cnt_q;
	logic [INDEX_BITS-1:0]     row_q;
	logic signed [VALUE_W-1:0] max_q;
	logic [BANK_W-1:0]         bank_q;

	logic                      accept;
	logic                      store;
	logic [INDEX_BITS-1:0]     cur_row;
	logic signed [VALUE_W-1:0] neg;
	logic signed [VALUE_W-1:0] max_next;
	logic [CNT_W-1:0]          cnt_next;
	desc_t                     d;

	// both banks busy means a full queue
	assign entries.ready = !q_stat.full;
	assign accept        = entries.valid && entries.ready;

	assign cur_row  = (cnt_q == '0) ? entries.row_index : row_q;
	assign store    = (cnt_q < CNT_W'(MAX_ROW_LEN));
	assign neg      = neg_sat(entries.value);
	assign max_next = (store && (entries.column != cur_row) && (neg > max_q)) ? neg : max_q;
	assign cnt_next = store ? cnt_q + CNT_W'(1) : cnt_q;

	assign wr_en     = accept && store;
	assign wr_addr   = {bank_q, cnt_q[ADDR_W-1:0]};
	assign wr_column = entries.column;
	assign wr_value  = entries.value;

	assign push    = accept && entries.last_in_row;
	assign d.row   = cur_row;
	assign d.max   = max_next;
	assign d.count = cnt_next;
	assign desc    = d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			row_q  <= '0;
			max_q  <= Q_MIN;
			bank_q <= '0;
		end else if (accept) begin
			row_q <= cur_row;
			if (entries.last_in_row) begin
				// restart for the next row in the other bank
				cnt_q  <= '0;
				max_q  <= Q_MIN;
				bank_q <= bank_q + BANK_W'(1);
			end else begin
				cnt_q <= cnt_next;
				max_q <= max_next;
			end
		end
	end

endmodule

/* hdl/csc_back.sv */
// ----------------------------------------------------------------------------
// csc_back
// Holds the row banks, replays a finished row, classifies each entry against
// theta times the row maximum and numbers the strong ones.
// ----------------------------------------------------------------------------
module csc_back import csc_pkg::*; #(
	parameter  int MAX_ROW_LEN = DEF_MAX_ROW_LEN,
	parameter  int INDEX_BITS  = DEF_INDEX_BITS,
	localparam int ADDR_W      = $clog2(MAX_ROW_LEN),
	localparam int CNT_W       = $clog2(MAX_ROW_LEN + 1),
	localparam int DESC_W      = INDEX_BITS + VALUE_W + CNT_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [THETA_W-1:0]         theta,
	input  logic                       wr_en,
	input  logic [BANK_W+ADDR_W-1:0]   wr_addr,
	input  logic [INDEX_BITS-1:0]      wr_column,
	input  logic signed [VALUE_W-1:0]  wr_value,
	input  logic [DESC_W-1:0]          desc,
	input  csc_q_status_t              q_stat,
	output logic                       pop,
	csc_result_if.source               results
);
	localparam int MEM_DEPTH = ROW_BANKS << ADDR_W;
	localparam int LHS_W     = VALUE_W + 16;
	localparam int RHS_W     = THETA_W + 1 + VALUE_W;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_READ = 2'd1;
	localparam logic [1:0] B_EMIT = 2'd2;

	typedef struct packed {
		logic [INDEX_BITS-1:0]     row;
		logic signed [VALUE_W-1:0] max;
		logic [CNT_W-1:0]          count;
	} desc_t;

	logic [INDEX_BITS-1:0]     col_mem [MEM_DEPTH];
	logic signed [VALUE_W-1:0] val_mem [MEM_DEPTH];

	logic [1:0]                state_q;
	logic [CNT_W-1:0]          k_q;
	logic [BANK_W-1:0]         bank_q;
	logic signed [RHS_W-1:0]   rhs_q;
	logic [POS_W-1:0]          total_q;
	logic [INDEX_BITS-1:0]     rd_col_q;
	logic signed [VALUE_W-1:0] rd_val_q;

	logic                      out_valid_q;
	logic [INDEX_BITS-1:0]     out_col_q;
	logic signed [VALUE_W-1:0] out_val_q;
	logic                      strong_q;
	logic [POS_W-1:0]          pos_q;
	logic                      done_q;

	desc_t                     head;
	logic [BANK_W+ADDR_W-1:0]  rd_addr;
	logic signed [LHS_W-1:0]   lhs;
	logic signed [RHS_W-1:0]   lhs_ext;
	logic                      strong_hit;
	logic                      load;
	logic [CNT_W-1:0]          k_next;
	logic                      last_k;

	assign head    = desc_t'(desc);
	assign rd_addr = {bank_q, k_q[ADDR_W-1:0]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			col_mem[wr_addr] <= wr_column;
			val_mem[wr_addr] <= wr_value;
		end
		rd_col_q <= col_mem[rd_addr];
		rd_val_q <= val_mem[rd_addr];
	end

	// -value * 65536 against theta * max, exact
	assign lhs        = {neg_sat(rd_val_q), 16'h0000};
	assign lhs_ext    = {{(RHS_W-LHS_W){lhs[LHS_W-1]}}, lhs};
	assign strong_hit = (rd_col_q != head.row) && (lhs_ext >= rhs_q);

	assign load   = (state_q == B_EMIT) && (!out_valid_q || results.ready);
	assign k_next = k_q + CNT_W'(1);
	assign last_k = (k_next == head.count);
	assign pop    = load && last_k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			k_q     <= '0;
			bank_q  <= '0;
			total_q <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (q_stat.valid) begin
						k_q     <= '0;
						state_q <= B_READ;
					end
				end
				B_READ: begin
					state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (load) begin
						if (strong_hit && (total_q != POS_MAX)) begin
							total_q <= total_q + POS_W'(1);
						end
						if (last_k) begin
							bank_q  <= bank_q + BANK_W'(1);
							state_q <= B_IDLE;
						end else begin
							k_q     <= k_next;
							state_q <= B_READ;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// threshold product, fixed for the whole row
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE) begin
			rhs_q <= $signed({1'b0, theta}) * $signed(head.max);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_col_q <= rd_col_q;
			out_val_q <= rd_val_q;
			strong_q  <= strong_hit;
			pos_q     <= strong_hit ? total_q : '0;
			done_q    <= last_k;
		end
	end

	assign results.valid            = out_valid_q;
	assign results.out_column       = out_col_q;
	assign results.out_value        = out_val_q;
	assign results.strong_res       = strong_q;
	assign results.compact_position = pos_q;
	assign results.row_done         = done_q;

endmodule

/* hdl/classical_strength_of_connection.sv */
// ----------------------------------------------------------------------------
// classical_strength_of_connection: one input word per cycle into a row bank while
// a bank is free (ready drops when both banks hold rows); after a row's last word
// the back forms the threshold, then per entry reads the bank and loads the output.
// Two banks let the next row fill while the previous one drains.
// Reset (async, active low) empties both banks, clears the strong count, theta=16384.
// ----------------------------------------------------------------------------
module classical_strength_of_connection import csc_pkg::*; #(
	parameter int MAX_ROW_LEN = DEF_MAX_ROW_LEN,
	parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	csc_entry_if.sink             entries,
	csc_result_if.source          results,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	localparam int ADDR_W = $clog2(MAX_ROW_LEN);
	localparam int CNT_W  = $clog2(MAX_ROW_LEN + 1);
	localparam int DESC_W = INDEX_BITS + VALUE_W + CNT_W;

	logic [THETA_W-1:0]        theta_q;
	logic                      cfg_write;
	logic                      sel_theta;

	logic                      wr_en;
	logic [BANK_W+ADDR_W-1:0]  wr_addr;
	logic [INDEX_BITS-1:0]     wr_column;
	logic signed [VALUE_W-1:0] wr_value;
	logic                      q_push;
	logic                      q_pop;
	logic [DESC_W-1:0]         push_desc;
	logic [DESC_W-1:0]         head_desc;
	csc_q_status_t             q_stat;

	assign pready    = 1'b1;
	assign sel_theta = (paddr[APB_ADDR_W-1:2] == REG_THETA);
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = sel_theta ? {{(32-THETA_W){1'b0}}, theta_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			theta_q <= THETA_RESET;
		end else if (cfg_write && sel_theta) begin
			theta_q <= pwdata[THETA_W-1:0];
		end
	end

	csc_front #(
		.MAX_ROW_LEN(MAX_ROW_LEN),
		.INDEX_BITS (INDEX_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.entries  (entries),
		.q_stat   (q_stat),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_column(wr_column),
		.wr_value (wr_value),
		.push     (q_push),
		.desc     (push_desc)
	);

	csc_queue #(
		.WIDTH(DESC_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(push_desc),
		.pop      (q_pop),
		.pop_data (head_desc),
		.stat     (q_stat)
	);

	csc_back #(
		.MAX_ROW_LEN(MAX_ROW_LEN),
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.theta    (theta_q),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_column(wr_column),
		.wr_value (wr_value),
		.desc     (head_desc),
		.q_stat   (q_stat),
		.pop      (q_pop),
		.results  (results)
	);

`ifndef ASSERT_OFF
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("row descriptor pushed into a full queue");

	a_pop_has_row: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_stat.valid)
		else $error("row descriptor popped from an empty queue");

	a_weak_no_position: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.strong_res |-> results.compact_position == '0)
		else $error("weak entry carries a strength matrix position");
`endif

endmodule

/* tb/tb_classical_strength_of_connection.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_classical_strength_of_connection
// Streams sparse rows into the strength of connection block with random input gaps
// and random result backpressure, and steps theta through several settings over
// APB. A scoreboard predicts, per row, each classified entry with its strong
// flag and compacted position, and compares every result word in order.
// ----------------------------------------------------------------------------
module tb_classical_strength_of_connection;
	import csc_pkg::*;

	localparam int CLK_PERIOD    = 20;
	localparam int RESET_CYCLES  = 8;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 200;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_ITEMS  = 370;
	localparam int PHASES        = 5;
	localparam int REPORT_LIMIT  = 40;
	localparam int ROW_LEN       = DEF_MAX_ROW_LEN;
	localparam int IDX_W         = DEF_INDEX_BITS;

	localparam logic [IDX_W-1:0]          IDX_ALL    = {IDX_W{1'b1}};
	localparam logic signed [VALUE_W-1:0] ONE        = 32'sh0001_0000;
	localparam logic [APB_ADDR_W-1:0]     THETA_ADDR = {REG_THETA, 2'b00};

	typedef struct {
		logic [IDX_W-1:0]          column;
		logic signed [VALUE_W-1:0] value;
		logic                      is_strong;
		logic [POS_W-1:0]          position;
		logic                      done;
	} classified_t;

	class strength_scoreboard;
		bit [THETA_W-1:0]         theta = THETA_RESET;
		bit [IDX_W-1:0]           col_buf [ROW_LEN];
		bit signed [VALUE_W-1:0]  val_buf [ROW_LEN];
		int unsigned              fill = 0;
		bit [IDX_W-1:0]           row_latch = '0;
		bit signed [VALUE_W-1:0]  max_neg = Q_MIN;
		bit [POS_W-1:0]           strong_count = '0;
		classified_t              expected_q [$];
		int unsigned              mismatches = 0;

		function automatic bit signed [VALUE_W-1:0] negated(bit signed [VALUE_W-1:0] v);
			longint n;
			n = -longint'(v);
			if (n > longint'(Q_MAX)) begin
				n = longint'(Q_MAX);
			end
			return n[VALUE_W-1:0];
		endfunction

		task report_mismatch(string msg);
			if (mismatches < REPORT_LIMIT) begin
				$display("%0t mismatch: %s", $time, msg);
			end
			mismatches++;
		endtask

		function int pending_count();
			return expected_q.size();
		endfunction

		// classify the buffered row when its last word arrives
		function void note_entry(bit [IDX_W-1:0] row, bit [IDX_W-1:0] col,
				bit signed [VALUE_W-1:0] val, bit last);
			classified_t c;
			longint lhs;
			longint rhs;
			if (fill == 0) begin
				row_latch = row;
			end
			if (fill < ROW_LEN) begin
				col_buf[fill] = col;
				val_buf[fill] = val;
				fill++;
				if (col != row_latch && negated(val) > max_neg) begin
					max_neg = negated(val);
				end
			end
			if (last) begin
				rhs = longint'(theta) * longint'(max_neg);
				for (int k = 0; k < fill; k++) begin
					lhs = longint'(negated(val_buf[k])) * 65536;
					c.column    = col_buf[k];
					c.value     = val_buf[k];
					c.is_strong = (col_buf[k] != row_latch) && (lhs >= rhs);
					c.position  = '0;
					if (c.is_strong) begin
						c.position = strong_count;
						if (strong_count != POS_MAX) begin
							strong_count++;
						end
					end
					c.done = (k == fill - 1);
					expected_q.push_back(c);
				end
				fill = 0;
				max_neg = Q_MIN;
			end
		endfunction

		task check_result(classified_t got);
			classified_t e;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result word with nothing expected, column %h",
					got.column));
			end else begin
				e = expected_q.pop_front();
				if (got.column !== e.column)
					report_mismatch($sformatf("out_column %h, expected %h", got.column, e.column));
				if (got.value !== e.value)
					report_mismatch($sformatf("out_value %h, expected %h", got.value, e.value));
				if (got.is_strong !== e.is_strong)
					report_mismatch($sformatf("strong_res %b, expected %b, column %h",
						got.is_strong, e.is_strong, e.column));
				if (got.position !== e.position)
					report_mismatch($sformatf("compact_position %h, expected %h",
						got.position, e.position));
				if (got.done !== e.done)
					report_mismatch($sformatf("row_done %b, expected %b", got.done, e.done));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	csc_entry_if  #(.INDEX_BITS(IDX_W)) ent_if ();
	csc_result_if #(.INDEX_BITS(IDX_W)) res_if ();

	strength_scoreboard sb = new();

	bit          quiet = 1'b0;
	bit          calm_row = 1'b0;
	bit          hold_off_req = 1'b0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;

	classical_strength_of_connection dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.entries (ent_if),
		.results (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		classified_t got;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.column    = res_if.out_column;
			got.value     = res_if.out_value;
			got.is_strong = res_if.strong_res;
			got.position  = res_if.compact_position;
			got.done      = res_if.row_done;
			sb.check_result(got);
		end
	end

	// receiver: random stall bursts, calm stretches, and one long hold-off on request
	initial begin
		int stall_left;
		int calm_left;
		int held;
		stall_left = 0;
		calm_left = 0;
		held = 0;
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				res_if.ready <= 1'b0;
				held++;
				if (held >= HOLD_CYCLES) begin
					hold_off_req = 1'b0;
					held = 0;
				end
			end else if (quiet || calm_left > 0) begin
				res_if.ready <= 1'b1;
				if (calm_left > 0)
					calm_left--;
			end else if (stall_left > 0) begin
				res_if.ready <= 1'b0;
				stall_left--;
			end else begin
				case ($urandom_range(0, 9))
					0, 1: begin
						res_if.ready <= 1'b0;
						stall_left = $urandom_range(0, 8);
					end
					2: begin
						res_if.ready <= 1'b1;
						calm_left = $urandom_range(20, 60);
					end
					default: res_if.ready <= 1'b1;
				endcase
			end
		end
	end

	task automatic send_entry(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
			input logic signed [VALUE_W-1:0] val, input bit last);
		ent_if.valid       <= 1'b1;
		ent_if.row_index   <= row;
		ent_if.column      <= col;
		ent_if.value       <= val;
		ent_if.last_in_row <= last;
		do @(posedge clk); while (!ent_if.ready);
		sb.note_entry(row, col, val, last);
		items_sent++;
	endtask

	task automatic item_gap();
		if (!quiet && !calm_row && $urandom_range(0, 3) == 0) begin
			ent_if.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// drop valid, wait for every expected word, then let the block settle
	task automatic wait_drained();
		ent_if.valid <= 1'b0;
		while (sb.pending_count() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_theta(input logic [THETA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= THETA_ADDR;
		pwdata  <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.theta = val;
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		logic signed [VALUE_W-1:0] v;
		case ($urandom_range(0, 7))
			0, 1: v = $urandom;
			2: v = $urandom_range(0, 32'h0003_0000);
			3: begin
				case ($urandom_range(0, 4))
					0: v = Q_MIN;
					1: v = Q_MAX;
					2: v = '0;
					3: v = -1;
					default: v = -ONE;
				endcase
			end
			4, 5: begin
				v = $urandom_range(1, 32'h0008_0000);
				v = -v;
			end
			default: begin
				v = $urandom_range(1, 32'h7FFF_FFFF);
				v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic logic [IDX_W-1:0] pick_column(input logic [IDX_W-1:0] row);
		logic [IDX_W-1:0] c;
		case ($urandom_range(0, 9))
			0, 1: c = row;
			2, 3, 4, 5: c = IDX_W'($urandom);
			default: c = row + IDX_W'($urandom_range(1, 16));
		endcase
		return c;
	endfunction

	// mostly short well-formed rows; some full, some overflowing, some with a wandering row index
	task automatic send_random_row();
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] ri;
		int len;
		bit noisy;
		case ($urandom_range(0, 19))
			0, 1, 2: len = $urandom_range(7, ROW_LEN - 1);
			3, 4: len = ROW_LEN;
			5: len = $urandom_range(ROW_LEN + 1, ROW_LEN + 4);
			default: len = $urandom_range(1, 6);
		endcase
		noisy = ($urandom_range(0, 9) == 0);
		calm_row = ($urandom_range(0, 3) == 0);
		r = IDX_W'($urandom);
		for (int k = 0; k < len; k++) begin
			ri = (noisy && $urandom_range(0, 1) == 1) ? IDX_W'($urandom) : r;
			send_entry(ri, pick_column(r), pick_value(), k == len - 1);
			item_gap();
		end
	endtask

	initial begin
		logic [THETA_W-1:0] theta_plan [PHASES];
		int unsigned target;
		theta_plan[0] = 17'd65536;
		theta_plan[1] = 17'd0;
		theta_plan[2] = {THETA_W{1'b1}};
		theta_plan[3] = THETA_W'($urandom_range(1, 65535));
		theta_plan[4] = 17'd32768;

		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		ent_if.valid        = 1'b0;
		ent_if.row_index    = '0;
		ent_if.column       = '0;
		ent_if.value        = '0;
		ent_if.last_in_row  = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at the reset threshold of one quarter
		send_entry(5, 5, ONE, 0);
		send_entry(5, 3, -ONE, 0);
		send_entry(5, 7, Q_MIN, 0);
		send_entry(5, 2, -32'sh2000_0000, 0);
		send_entry(5, 4, -32'sh1FFF_FFFF, 0);
		send_entry(5, 9, Q_MAX, 0);
		send_entry(5, 1, 0, 1);
		item_gap();
		// a diagonal-only row, where nothing can be strong, then a one-entry off-diagonal row
		send_entry(IDX_ALL, IDX_ALL, Q_MIN, 0);
		send_entry(IDX_ALL, IDX_ALL, -ONE, 1);
		send_entry(0, IDX_ALL, -1, 1);
		item_gap();
		// row index moves mid-row; the first one holds
		send_entry(10, 20, -2 * ONE, 0);
		send_entry(20, 20, -4 * ONE, 0);
		send_entry(20, 10, 3, 1);
		send_entry(0, 0, 0, 1);
		send_entry(IDX_ALL, 0, Q_MAX, 1);
		// exact tie with the threshold, and one step below it
		send_entry(100, 101, -4 * ONE, 0);
		send_entry(100, 102, -ONE, 0);
		send_entry(100, 103, -ONE + 1, 1);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			write_theta(theta_plan[p]);
			quiet = (p == PHASES - 1);
			if (p == 1)
				hold_off_req = 1'b1;
			target = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < target)
				send_random_row();
		end
		wait_drained();

		if (sb.mismatches == 0 && sb.pending_count() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* files.f */
hdl/csc_pkg.sv
hdl/csc_entry_if.sv
hdl/csc_result_if.sv
hdl/csc_queue.sv
hdl/csc_front.sv
hdl/csc_back.sv
hdl/classical_strength_of_connection.sv
tb/tb_classical_strength_of_connection.sv
